[src/nearest_point_within_radius_defines.svh]
// ----------------------------------------------------------------------------
// Nearest point within radius: assertion macros
// Shared macros for concurrent assertions in the checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_WITHIN_RADIUS_DEFINES_SVH
`define NEAREST_POINT_WITHIN_RADIUS_DEFINES_SVH

// Assertion that is switched off while reset is active.
`define NPWR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assertion that is also checked during reset.
`define NPWR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/npwr_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest point within radius: package
// Shared constants, request codes and the metadata record of a beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npwr_pkg;

  localparam int unsigned NUM_POINTS_DEF  = 16;
  localparam int unsigned COORD_BITS_DEF  = 21;
  localparam int unsigned TAG_BITS        = 32;
  localparam int unsigned RADIUS_BITS     = 20;
  localparam int unsigned R2_BITS         = 2 * RADIUS_BITS;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RST = 20'd1000;
  localparam logic [R2_BITS-1:0]     R2_RST     = 40'd1000000;

  typedef enum logic {
    REQ_REF   = 1'b0,
    REQ_POINT = 1'b1
  } req_type_e;

  typedef struct packed {
    logic                is_ref;
    logic                in_range;
    logic                last;
    logic [TAG_BITS-1:0] tag;
  } meta_t;

endpackage

[src/npwr_req_if.sv]
// ----------------------------------------------------------------------------
// Nearest point within radius: request channel
// Valid/ready channel carrying reference and point beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface npwr_req_if #(
  parameter int unsigned COORD_BITS = npwr_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = 5
) ();
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [ID_BITS-1:0]              point_id;
  logic signed [COORD_BITS-1:0]    pos_x;
  logic signed [COORD_BITS-1:0]    pos_y;
  logic signed [COORD_BITS-1:0]    pos_z;
  logic [npwr_pkg::TAG_BITS-1:0]   frame_tag;
  logic                            last;

  modport source (
    output valid, req_type, point_id, pos_x, pos_y, pos_z, frame_tag, last,
    input  ready
  );

  modport sink (
    input  valid, req_type, point_id, pos_x, pos_y, pos_z, frame_tag, last,
    output ready
  );
endinterface

[src/npwr_rsp_if.sv]
// ----------------------------------------------------------------------------
// Nearest point within radius: result channel
// Valid/ready channel carrying one result beat per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface npwr_rsp_if #(
  parameter int unsigned ID_BITS = 5
) ();
  logic                          valid;
  logic                          ready;
  logic [ID_BITS-1:0]            holder;
  logic [npwr_pkg::TAG_BITS-1:0] tag_out;

  modport source (
    output valid, holder, tag_out,
    input  ready
  );

  modport sink (
    input  valid, holder, tag_out,
    output ready
  );
endinterface

[src/npwr_dist.sv]
// ----------------------------------------------------------------------------
// Nearest point within radius: distance pipeline
// Input register, absolute coordinate differences and squares, with the
// reference position and frame tag held per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npwr_dist #(
  parameter int unsigned NUM_POINTS = npwr_pkg::NUM_POINTS_DEF,
  parameter int unsigned COORD_BITS = npwr_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = $clog2(NUM_POINTS + 1),
  parameter int unsigned SQ_BITS    = 2 * COORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  npwr_req_if.sink             req_i,
  output logic                 dn_valid_o,
  input  logic                 dn_ready_i,
  output logic [SQ_BITS-1:0]   sq_x_o,
  output logic [SQ_BITS-1:0]   sq_y_o,
  output logic [SQ_BITS-1:0]   sq_z_o,
  output logic [ID_BITS-1:0]   id_o,
  output npwr_pkg::meta_t      meta_o
);

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    begin
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      return d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
    end
  endfunction

  logic                          v1_q, v2_q, v3_q;
  logic                          en1, en2, en3;
  logic                          type1_q;
  logic [ID_BITS-1:0]            id1_q, id2_q, id3_q;
  logic [COORD_BITS-1:0]         x1_q, y1_q, z1_q;
  logic [npwr_pkg::TAG_BITS-1:0] tag1_q;
  logic                          last1_q;
  logic [COORD_BITS-1:0]         ref_x_q, ref_y_q, ref_z_q;
  logic [npwr_pkg::TAG_BITS-1:0] held_tag_q;
  logic [COORD_BITS-1:0]         abs_x_q, abs_y_q, abs_z_q;
  logic [SQ_BITS-1:0]            sq_x_q, sq_y_q, sq_z_q;
  npwr_pkg::meta_t               meta2_d, meta2_q, meta3_q;
  logic                          is_ref1;
  logic                          ref_upd;

  assign en3         = !v3_q || dn_ready_i;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign req_i.ready = en1;

  assign is_ref1 = (type1_q == npwr_pkg::REQ_REF);
  assign ref_upd = v1_q && en2 && is_ref1;

  always_comb begin
    meta2_d.is_ref   = is_ref1;
    meta2_d.in_range = (id1_q != '0) && (id1_q <= ID_BITS'(NUM_POINTS));
    meta2_d.last     = last1_q;
    meta2_d.tag      = is_ref1 ? tag1_q : held_tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      ref_x_q    <= '0;
      ref_y_q    <= '0;
      ref_z_q    <= '0;
      held_tag_q <= '0;
    end else begin
      if (en1) begin
        v1_q <= req_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (ref_upd) begin
        ref_x_q    <= x1_q;
        ref_y_q    <= y1_q;
        ref_z_q    <= z1_q;
        held_tag_q <= tag1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && en1) begin
      type1_q <= req_i.req_type;
      id1_q   <= req_i.point_id;
      x1_q    <= req_i.pos_x;
      y1_q    <= req_i.pos_y;
      z1_q    <= req_i.pos_z;
      tag1_q  <= req_i.frame_tag;
      last1_q <= req_i.last;
    end
    if (v1_q && en2) begin
      abs_x_q <= abs_diff(x1_q, ref_x_q);
      abs_y_q <= abs_diff(y1_q, ref_y_q);
      abs_z_q <= abs_diff(z1_q, ref_z_q);
      id2_q   <= id1_q;
      meta2_q <= meta2_d;
    end
    if (v2_q && en3) begin
      sq_x_q  <= SQ_BITS'(abs_x_q) * SQ_BITS'(abs_x_q);
      sq_y_q  <= SQ_BITS'(abs_y_q) * SQ_BITS'(abs_y_q);
      sq_z_q  <= SQ_BITS'(abs_z_q) * SQ_BITS'(abs_z_q);
      id3_q   <= id2_q;
      meta3_q <= meta2_q;
    end
  end

  assign dn_valid_o = v3_q;
  assign sq_x_o     = sq_x_q;
  assign sq_y_o     = sq_y_q;
  assign sq_z_o     = sq_z_q;
  assign id_o       = id3_q;
  assign meta_o     = meta3_q;

endmodule

[src/npwr_min.sv]
// ----------------------------------------------------------------------------
// Nearest point within radius: running minimum and result
// Sums the squares, keeps the frame minimum and its id, and applies the
// radius test into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npwr_min #(
  parameter int unsigned NUM_POINTS = npwr_pkg::NUM_POINTS_DEF,
  parameter int unsigned COORD_BITS = npwr_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = $clog2(NUM_POINTS + 1),
  parameter int unsigned SQ_BITS    = 2 * COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             up_valid_i,
  output logic                             up_ready_o,
  input  logic [SQ_BITS-1:0]               sq_x_i,
  input  logic [SQ_BITS-1:0]               sq_y_i,
  input  logic [SQ_BITS-1:0]               sq_z_i,
  input  logic [ID_BITS-1:0]               id_i,
  input  npwr_pkg::meta_t                  meta_i,
  input  logic                             cfg_we_i,
  input  logic [npwr_pkg::RADIUS_BITS-1:0] cfg_wdata_i,
  npwr_rsp_if.source                       rsp_o
);

  localparam int unsigned DIST_BITS = SQ_BITS + 2;
  localparam int unsigned CMP_BITS  =
    (DIST_BITS > npwr_pkg::R2_BITS) ? DIST_BITS : npwr_pkg::R2_BITS;

  logic [npwr_pkg::RADIUS_BITS-1:0] radius_q;
  logic [npwr_pkg::R2_BITS-1:0]     r2_q;
  logic [DIST_BITS-1:0]             best_q, dist4_q;
  logic [ID_BITS-1:0]               best_id_q, id4_q;
  logic [npwr_pkg::TAG_BITS-1:0]    tag4_q;
  logic [ID_BITS-1:0]               holder_q;
  logic [npwr_pkg::TAG_BITS-1:0]    tag_out_q;
  logic                             v4_q, out_v_q;
  logic                             en_out, en4, acc;
  logic [DIST_BITS-1:0]             sum, eff_dist;
  logic [ID_BITS-1:0]               eff_id;
  logic                             take, frame_end;

  assign en_out     = !out_v_q || rsp_o.ready;
  assign en4        = !v4_q || en_out;
  assign up_ready_o = en4;
  assign acc        = up_valid_i && en4;

  assign sum       = DIST_BITS'(sq_x_i) + DIST_BITS'(sq_y_i) + DIST_BITS'(sq_z_i);
  assign take      = meta_i.in_range && (sum < best_q);
  assign eff_dist  = take ? sum : best_q;
  assign eff_id    = take ? id_i : best_id_q;
  assign frame_end = !meta_i.is_ref && meta_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= npwr_pkg::RADIUS_RST;
      r2_q      <= npwr_pkg::R2_RST;
      best_q    <= '1;
      best_id_q <= '0;
      v4_q      <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      r2_q <= npwr_pkg::R2_BITS'(radius_q) * npwr_pkg::R2_BITS'(radius_q);
      if (acc) begin
        if (meta_i.is_ref || meta_i.last) begin
          best_q    <= '1;
          best_id_q <= '0;
        end else begin
          best_q    <= eff_dist;
          best_id_q <= eff_id;
        end
      end
      if (en4) begin
        v4_q <= up_valid_i && frame_end;
      end
      if (en_out) begin
        out_v_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && frame_end) begin
      dist4_q <= eff_dist;
      id4_q   <= eff_id;
      tag4_q  <= meta_i.tag;
    end
    if (v4_q && en_out) begin
      holder_q  <= (CMP_BITS'(dist4_q) > CMP_BITS'(r2_q)) ? '0 : id4_q;
      tag_out_q <= tag4_q;
    end
  end

  assign rsp_o.valid   = out_v_q;
  assign rsp_o.holder  = holder_q;
  assign rsp_o.tag_out = tag_out_q;

endmodule

[src/nearest_point_within_radius.sv]
// ----------------------------------------------------------------------------
// Nearest point within radius: top level
// Per frame, reports the id of the point nearest to the reference position
// when it lies within the configured radius, with the frame tag.
//
//   Channel  Dir  Handshake        Payload
//   req_i    in   valid / ready    req_type, point_id, pos_x/y/z, frame_tag, last
//   rsp_o    out  valid / ready    holder, tag_out
//   cfg      in   cfg_we_i         cfg_wdata_i (radius)
//
// One beat is accepted per cycle while req_i.ready is high. A result is valid
// once its closing point beat has passed the input register, the differences,
// squares, minimum update and radius test, which each take one register stage.
// Reset is asynchronous and needs no clearing pass.
// Each stage moves on when the stage after it is free, so bubbles absorb
// output stalls and req_i.ready drops only when every stage is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_point_within_radius #(
  parameter int unsigned NUM_POINTS = npwr_pkg::NUM_POINTS_DEF,
  parameter int unsigned COORD_BITS = npwr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  npwr_req_if.sink                         req_i,
  npwr_rsp_if.source                       rsp_o,
  input  logic                             cfg_we_i,
  input  logic [npwr_pkg::RADIUS_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned ID_BITS = $clog2(NUM_POINTS + 1);
  localparam int unsigned SQ_BITS = 2 * COORD_BITS;

  logic                 dn_valid;
  logic                 dn_ready;
  logic [SQ_BITS-1:0]   sq_x, sq_y, sq_z;
  logic [ID_BITS-1:0]   dn_id;
  npwr_pkg::meta_t      dn_meta;

  npwr_dist #(
    .NUM_POINTS (NUM_POINTS),
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS),
    .SQ_BITS    (SQ_BITS)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .dn_valid_o (dn_valid),
    .dn_ready_i (dn_ready),
    .sq_x_o     (sq_x),
    .sq_y_o     (sq_y),
    .sq_z_o     (sq_z),
    .id_o       (dn_id),
    .meta_o     (dn_meta)
  );

  npwr_min #(
    .NUM_POINTS (NUM_POINTS),
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS),
    .SQ_BITS    (SQ_BITS)
  ) u_min (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (dn_valid),
    .up_ready_o  (dn_ready),
    .sq_x_i      (sq_x),
    .sq_y_i      (sq_y),
    .sq_z_i      (sq_z),
    .id_i        (dn_id),
    .meta_i      (dn_meta),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

endmodule

[src/npwr_checker.sv]
// ----------------------------------------------------------------------------
// Nearest point within radius: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_point_within_radius_defines.svh"

module npwr_checker #(
  parameter int unsigned NUM_POINTS = npwr_pkg::NUM_POINTS_DEF,
  parameter int unsigned ID_BITS    = $clog2(NUM_POINTS + 1)
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ID_BITS-1:0]            holder_i,
  input logic [npwr_pkg::TAG_BITS-1:0] tag_out_i
);

  `NPWR_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !rsp_valid_i, "result valid during reset")
  `NPWR_ASSERT(a_result_held, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(holder_i) && $stable(tag_out_i), "stalled result changed")
  `NPWR_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, !req_ready_i |-> rsp_valid_i && !rsp_ready_i, "input stalled without output stall")
  `NPWR_ASSERT(a_holder_range, clk_i, rst_ni, rsp_valid_i |-> holder_i <= ID_BITS'(NUM_POINTS), "holder id out of range")

endmodule

bind nearest_point_within_radius npwr_checker #(
  .NUM_POINTS (NUM_POINTS)
) u_npwr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .holder_i    (rsp_o.holder),
  .tag_out_i   (rsp_o.tag_out)
);
